// ===== rtl/leased_resource_admission_defines.svh =====
// ----------------------------------------------------------------------------
// Leased resource admission assertion macros
// Shared assertion forms for the admission control modules.
// ----------------------------------------------------------------------------
`ifndef LEASED_RESOURCE_ADMISSION_DEFINES_SVH
`define LEASED_RESOURCE_ADMISSION_DEFINES_SVH

// A condition that implies a consequence on the same edge.
`define LRA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// A condition that implies a consequence on the next edge.
`define LRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/lra_pkg.sv =====
// ----------------------------------------------------------------------------
// Leased resource admission package
// Item types, status codes and register indexes.
// ----------------------------------------------------------------------------
package lra_pkg;

  localparam logic [1:0] ST_GRANT  = 2'd0;
  localparam logic [1:0] ST_REFUSE = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [0:0] REG_TOTAL_CAPACITY = 1'd0;
  localparam logic [0:0] REG_LEASE_TICKS    = 1'd1;

  localparam logic [31:0] CAP_RESET   = 32'd65536;
  localparam logic [15:0] LEASE_RESET = 16'd1000;

  typedef struct packed {
    logic        mode;
    logic [31:0] client_key;
    logic [31:0] amount;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] held_amount;
    logic [31:0] remaining;
  } resp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] held;
    logic [15:0] age;
  } entry_t;

endpackage

// ===== rtl/leased_resource_admission.sv =====
// ----------------------------------------------------------------------------
// Leased resource admission
// Admission control for a shared pool with leased client entries.
//
// Channel   Ports                          Handshake
// request   start, busy, req               start high while busy low
// result    done, resp                     done high for one cycle
// config    cfg_we, cfg_index, cfg_data    cfg_we high
//
// A request keeps busy high through its table scan and, unless the table
// is full, the slot update; a tick keeps busy high through its own scan
// and gives no result. The single memory read port reads one entry per cycle.
// A request first scans for its key, then, unless the table is full, reads and writes the chosen slot.
// The result strobe comes in the same cycle that busy falls.
// Reset is synchronous and clears valid bits; the result cannot be stalled.
// ----------------------------------------------------------------------------
`include "leased_resource_admission_defines.svh"

module leased_resource_admission #(
  parameter int CLIENTS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  lra_pkg::req_t  req,
  output logic           done,
  output lra_pkg::resp_t resp,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  localparam int AW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam logic [AW:0] LAST = (AW+1)'(CLIENTS - 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_WAIT, S_DECIDE, S_TICK}
    state_t;

  state_t          state;
  lra_pkg::req_t   cur;
  logic [AW:0]     idx;
  logic [AW:0]     ridx;
  logic            rd_vld;
  logic [AW-1:0]   slot;
  logic            found;
  logic            have_free;
  logic [AW-1:0]   free_idx;
  logic [CLIENTS-1:0] valid;
  logic [31:0]     pool;
  logic [15:0]     lease;

  logic [AW-1:0]   rd_addr;
  lra_pkg::entry_t rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  lra_pkg::entry_t wr_data;

  logic [32:0]     avail;
  logic [32:0]     sum;
  logic [15:0]     age_inc;
  logic            expire;
  logic [15:0]     lease_eff;
  logic [AW-1:0]   ridx_a;

  lra_table #(.CLIENTS(CLIENTS), .AW(AW)) u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign busy = (state != S_IDLE);
  assign ridx_a = ridx[AW-1:0];
  assign lease_eff = (lease == 16'd0) ? 16'd1 : lease;
  assign age_inc = rd_data.age + 16'd1;
  assign expire = (age_inc >= lease_eff) || (age_inc == 16'd0);
  assign avail = {1'b0, pool} + (found ? {1'b0, rd_data.held} : 33'd0);
  assign sum = {1'b0, pool} + {1'b0, rd_data.held};

  always_comb begin
    rd_addr = idx[AW-1:0];
    if (state == S_READ || state == S_WAIT) begin
      rd_addr = slot;
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = slot;
    wr_data = rd_data;
    if (state == S_DECIDE) begin
      wr_en = 1'b1;
      wr_data.key = cur.client_key;
      wr_data.age = 16'd0;
      if (!found) begin
        wr_data.held = 32'd0;
      end
      if ({1'b0, cur.amount} <= avail) begin
        wr_data.held = cur.amount;
      end
    end else if (state == S_TICK && rd_vld && valid[ridx_a]) begin
      wr_en = 1'b1;
      wr_addr = ridx_a;
      wr_data.age = age_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      pool <= lra_pkg::CAP_RESET;
      lease <= lra_pkg::LEASE_RESET;
      done <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          lra_pkg::REG_TOTAL_CAPACITY: pool <= cfg_data;
          lra_pkg::REG_LEASE_TICKS: lease <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= req;
            idx <= '0;
            rd_vld <= 1'b0;
            found <= 1'b0;
            have_free <= 1'b0;
            state <= req.mode ? S_TICK : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_vld && !found && valid[ridx_a] && rd_data.key == cur.client_key) begin
            found <= 1'b1;
            slot <= ridx_a;
          end
          if (rd_vld && !have_free && !valid[ridx_a]) begin
            have_free <= 1'b1;
            free_idx <= ridx_a;
          end
          ridx <= idx;
          rd_vld <= (idx <= LAST);
          if (idx <= LAST) begin
            idx <= idx + 1'b1;
          end
          if (rd_vld && ridx == LAST) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (!found) begin
            if (have_free) begin
              slot <= free_idx;
              state <= S_WAIT;
            end else begin
              resp <= '{lra_pkg::ST_FULL, 32'd0, pool};
              done <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          valid[slot] <= 1'b1;
          done <= 1'b1;
          if ({1'b0, cur.amount} <= avail) begin
            if (avail - {1'b0, cur.amount} > 33'h0_FFFF_FFFF) begin
              pool <= 32'hFFFF_FFFF;
            end else begin
              pool <= 32'(avail - {1'b0, cur.amount});
            end
            resp <= '{lra_pkg::ST_GRANT, cur.amount,
                      32'(avail - {1'b0, cur.amount}) |
                      {32{(avail - {1'b0, cur.amount}) > 33'h0_FFFF_FFFF}}};
          end else begin
            resp <= '{lra_pkg::ST_REFUSE, found ? rd_data.held : 32'd0, pool};
          end
          state <= S_IDLE;
        end
        S_TICK: begin
          if (rd_vld && valid[ridx_a] && expire) begin
            valid[ridx_a] <= 1'b0;
            pool <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          end
          ridx <= idx;
          rd_vld <= (idx <= LAST);
          if (idx <= LAST) begin
            idx <= idx + 1'b1;
          end
          if (rd_vld && ridx == LAST) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LRA_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `LRA_ASSERT_IMPLY(a_done_idle, clk, rst, done, state == S_IDLE)
  `LRA_ASSERT_IMPLY(a_write_phase, clk, rst, wr_en, state == S_DECIDE || state == S_TICK)
  `LRA_ASSERT_NEXT(a_decide_done, clk, rst, state == S_DECIDE, done)

endmodule

// ===== rtl/lra_table.sv =====
// ----------------------------------------------------------------------------
// Leased resource admission client table
// Synchronous memory of key, held amount and lease age, one read port with
// registered data and one write port.
// ----------------------------------------------------------------------------
module lra_table #(
  parameter int CLIENTS = 32,
  parameter int AW = 5
) (
  input  logic             clk,
  input  logic [AW-1:0]    rd_addr,
  output lra_pkg::entry_t  rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  lra_pkg::entry_t  wr_data
);

  lra_pkg::entry_t mem [CLIENTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Leased resource admission testbench
// Drives requests and ticks through the command port, predicts every result
// with a local model of the client table and pool, and compares each result
// field by field. Runs directed cases, then random phases with sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CLIENTS = 32;
  localparam int LATENCY = 2 * CLIENTS + 3;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  lra_pkg::req_t req = '0;
  logic done;
  lra_pkg::resp_t resp;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = lra_pkg::REG_TOTAL_CAPACITY;
  logic [31:0] cfg_data = '0;

  leased_resource_admission #(.CLIENTS(CLIENTS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .resp(resp), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  lra_pkg::req_t pending_items[$];
  lra_pkg::resp_t expected_results[$];
  int gap_pct = 0;
  int failures = 0;
  int cycle_count = 0;

  logic [15:0] lease_q;
  logic        tbl_valid[CLIENTS];
  lra_pkg::entry_t tbl[CLIENTS];
  logic [31:0] pool_q;
  logic [31:0] keys_seen[$];

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic admit(input lra_pkg::req_t it);
    int slot;
    logic [32:0] avail;
    lra_pkg::resp_t r;
    slot = -1;
    if (it.mode) begin
      for (int i = 0; i < CLIENTS; i++) begin
        if (tbl_valid[i]) begin
          tbl[i].age = tbl[i].age + 16'd1;
          if (tbl[i].age >= lease_q || tbl[i].age == 16'd0) begin
            tbl_valid[i] = 1'b0;
            pool_q = sat_add(pool_q, tbl[i].held);
          end
        end
      end
      return;
    end
    for (int i = 0; i < CLIENTS && slot < 0; i++)
      if (tbl_valid[i] && tbl[i].key == it.client_key) slot = i;
    if (slot < 0) begin
      for (int i = 0; i < CLIENTS && slot < 0; i++)
        if (!tbl_valid[i]) slot = i;
      if (slot < 0) begin
        r.status = lra_pkg::ST_FULL;
        r.held_amount = '0;
        r.remaining = pool_q;
        expected_results.push_back(r);
        return;
      end
      tbl_valid[slot] = 1'b1;
      tbl[slot].key = it.client_key;
      tbl[slot].held = '0;
    end
    tbl[slot].age = '0;
    avail = {1'b0, pool_q} + {1'b0, tbl[slot].held};
    if ({1'b0, it.amount} > avail) begin
      r.status = lra_pkg::ST_REFUSE;
    end else begin
      avail = avail - {1'b0, it.amount};
      pool_q = avail[32] ? 32'hFFFF_FFFF : avail[31:0];
      tbl[slot].held = it.amount;
      r.status = lra_pkg::ST_GRANT;
    end
    r.held_amount = tbl[slot].held;
    r.remaining = pool_q;
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("[leased_resource_admission] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      admit(req);
      if (pending_items.size() > 0 && $urandom_range(99) >= gap_pct) begin
        req <= pending_items.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_items.size() > 0 &&
                 $urandom_range(99) >= gap_pct) begin
      req <= pending_items.pop_front();
      start <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting");
        failures++;
      end else begin
        lra_pkg::resp_t e;
        e = expected_results.pop_front();
        if (resp.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, resp.status);
          failures++;
        end
        if (resp.held_amount !== e.held_amount) begin
          $error("held_amount expected %h actual %h", e.held_amount, resp.held_amount);
          failures++;
        end
        if (resp.remaining !== e.remaining) begin
          $error("remaining expected %h actual %h", e.remaining, resp.remaining);
          failures++;
        end
      end
    end
  end

  function automatic lra_pkg::req_t make_req(logic [31:0] key, logic [31:0] amt);
    lra_pkg::req_t r;
    r.mode = 1'b0;
    r.client_key = key;
    r.amount = amt;
    return r;
  endfunction

  function automatic lra_pkg::req_t make_tick();
    lra_pkg::req_t r;
    r.mode = 1'b1;
    r.client_key = $urandom;
    r.amount = $urandom;
    return r;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lra_pkg::REG_TOTAL_CAPACITY) begin
      pool_q = val;
    end else begin
      lease_q = (val[15:0] == 16'd0) ? 16'd1 : val[15:0];
    end
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_amount();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(32'h0002_0000);
      2: return pool_q;
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'h0000_4000);
    endcase
  endfunction

  task automatic random_phase(int n, int pct, int key_space, int tick_pct);
    lra_pkg::req_t r;
    gap_pct = pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < tick_pct) begin
        r = make_tick();
      end else begin
        logic [31:0] k;
        if (keys_seen.size() > 0 && $urandom_range(99) < 70)
          k = keys_seen[$urandom_range(keys_seen.size() - 1)];
        else begin
          k = $urandom_range(key_space - 1);
          if ($urandom_range(9) == 0) k = $urandom;
          keys_seen.push_back(k);
          if (keys_seen.size() > 48) void'(keys_seen.pop_front());
        end
        r = make_req(k, rand_amount());
      end
      pending_items.push_back(r);
    end
    drain();
  endtask

  initial begin
    lease_q = lra_pkg::LEASE_RESET;
    pool_q = lra_pkg::CAP_RESET;
    for (int i = 0; i < CLIENTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    pending_items.push_back(make_req(32'h0, 32'h0));
    pending_items.push_back(make_req(32'hFFFF_FFFF, 32'h0001_0000));
    pending_items.push_back(make_req(32'h0, 32'h0000_8000));
    pending_items.push_back(make_req(32'h0, 32'hFFFF_FFFF));
    pending_items.push_back(make_req(32'hFFFF_FFFF, 32'h0));
    pending_items.push_back(make_req(32'h0, 32'h0001_0000));
    pending_items.push_back(make_tick());
    drain();
    write_reg(lra_pkg::REG_TOTAL_CAPACITY, 32'hFFFF_FFFF);
    write_reg(lra_pkg::REG_LEASE_TICKS, 32'd0);
    pending_items.push_back(make_req(32'h0, 32'h0));
    pending_items.push_back(make_req(32'h5555_AAAA, 32'hFFFF_FFFF));
    pending_items.push_back(make_tick());
    for (int i = 0; i < CLIENTS + 2; i++)
      pending_items.push_back(make_req(32'h100 + i, 32'h0));
    drain();
    pending_items.push_back(make_tick());
    drain();
    write_reg(lra_pkg::REG_LEASE_TICKS, 32'h0000_FFFF);
    write_reg(lra_pkg::REG_TOTAL_CAPACITY, 32'h0);

    random_phase(150, 30, 40, 10);
    write_reg(lra_pkg::REG_TOTAL_CAPACITY, 32'h0004_0000);
    write_reg(lra_pkg::REG_LEASE_TICKS, 32'd3);
    random_phase(400, 30, 48, 25);
    write_reg(lra_pkg::REG_LEASE_TICKS, 32'd1);
    random_phase(150, 53, 40, 20);
    write_reg(lra_pkg::REG_TOTAL_CAPACITY, $urandom);
    write_reg(lra_pkg::REG_LEASE_TICKS, 32'd6);
    random_phase(450, 53, 64, 20);
    write_reg(lra_pkg::REG_TOTAL_CAPACITY, 32'h0010_0000);
    write_reg(lra_pkg::REG_LEASE_TICKS, 32'd1000);
    random_phase(450, 0, 40, 10);

    if (expected_results.size() != 0) failures++;
    if (failures == 0)
      $display("[leased_resource_admission] OK");
    else
      $display("[leased_resource_admission] ERROR");
    $finish;
  end
endmodule
